FILE: sv/cfd_pkg.sv
`default_nettype none

package cfd_pkg;

  // Default number of byte slots in the receive store.
  localparam int DEF_STORE_DEPTH = 64;

  // Frame format constants.
  localparam logic [7:0] HDR_FIRST   = 8'hFF;
  localparam logic [7:0] HDR_SECOND  = 8'hFE;
  localparam int         MIN_FRAME   = 10;
  localparam int         MIN_LENGTH  = 4;
  localparam int         FRAME_EXTRA = 6;
  localparam int         LEN_OFF     = 2;
  localparam int         LEN_LAST    = 5;
  localparam int         CMD_OFF     = 6;
  localparam int         PAYLOAD_OFF = 8;
  localparam int         HDR_BYTES   = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHK,
    ST_LEN,
    ST_LCHK,
    ST_SUM,
    ST_SCHK,
    ST_EM_RD,
    ST_EM_WR
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_DROP,
    OP_CLEAR
  } op_e;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_LEN,
    CAP_CMD,
    CAP_SUM,
    CAP_WANT
  } cap_e;

  typedef struct packed {
    op_e  op;
    cap_e cap;
    logic clr_acc;
    logic load_out;
    logic out_empty;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic is_ff;
    logic is_fe;
    logic last_ff;
    logic short_store;
    logic len_bad;
    logic incomplete;
    logic sum_ok;
    logic empty_frame;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/cfd_ifs.sv
`default_nettype none

interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] command_code;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        frame_last;

  modport source (
    output valid, output command_code, output payload_byte,
    output byte_valid, output frame_last, input ready
  );
  modport sink (
    input valid, input command_code, input payload_byte,
    input byte_valid, input frame_last, output ready
  );
endinterface

`default_nettype wire

FILE: sv/cfd_dp.sv
`default_nettype none

module cfd_dp #(
  parameter int STORE_DEPTH = cfd_pkg::DEF_STORE_DEPTH,
  localparam int AW = $clog2(STORE_DEPTH),
  localparam int CW = $clog2(STORE_DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfd_pkg::cmd_t    cmd_i,
  input  wire logic [CW-1:0]    rd_off_i,
  input  wire logic [CW-1:0]    drop_amt_i,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             out_ready_i,
  output cfd_pkg::status_t      status_o,
  output logic [CW-1:0]         fill_o,
  output logic [CW-1:0]         total_o,
  output logic                  out_valid_o,
  output logic [15:0]           command_code_o,
  output logic [7:0]            payload_byte_o,
  output logic                  byte_valid_o,
  output logic                  frame_last_o
);

  logic [7:0]    mem_q [STORE_DEPTH];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [7:0]    last_q;
  logic [31:0]   len_q;
  logic [15:0]   cmd_q, sum_q, want_q;
  logic          out_valid_q;
  logic [15:0]   out_cmd_q;
  logic [7:0]    out_byte_q;
  logic          out_bv_q, out_last_q;

  logic [AW-1:0] rd_addr, wr_addr, drop_head;
  logic          full;

  // Ring index of a base plus an offset of at most the depth.
  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(STORE_DEPTH)) begin
      sum = sum - (CW+1)'(STORE_DEPTH);
    end
    return AW'(sum);
  endfunction

  assign full      = (fill_q == CW'(STORE_DEPTH));
  assign rd_addr   = ring_add(head_q, rd_off_i);
  assign wr_addr   = ring_add(head_q, fill_q);
  assign drop_head = ring_add(head_q, drop_amt_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == cfd_pkg::OP_PUSH) begin
      mem_q[wr_addr] <= in_byte_i;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    case (cmd_i.op)
      cfd_pkg::OP_PUSH: begin
        if (full) begin
          head_d = ring_add(head_q, CW'(1));
        end else begin
          fill_d = fill_q + CW'(1);
        end
      end
      cfd_pkg::OP_DROP: begin
        head_d = drop_head;
        fill_d = fill_q - drop_amt_i;
      end
      cfd_pkg::OP_CLEAR: begin
        fill_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == cfd_pkg::OP_PUSH) begin
      last_q <= in_byte_i;
    end
    if (cmd_i.clr_acc) begin
      sum_q <= '0;
    end
    case (cmd_i.cap)
      cfd_pkg::CAP_LEN:  len_q  <= {rd_data_q, len_q[31:8]};
      cfd_pkg::CAP_CMD:  cmd_q  <= {rd_data_q, cmd_q[15:8]};
      cfd_pkg::CAP_SUM:  sum_q  <= sum_q + 16'(rd_data_q);
      cfd_pkg::CAP_WANT: want_q <= {rd_data_q, want_q[15:8]};
      default: begin
      end
    endcase
    if (cmd_i.load_out) begin
      out_cmd_q  <= cmd_q;
      out_byte_q <= cmd_i.out_empty ? 8'h00 : rd_data_q;
      out_bv_q   <= ~cmd_i.out_empty;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign fill_o  = fill_q;
  assign total_o = len_q[CW-1:0] + CW'(cfd_pkg::FRAME_EXTRA);

  always_comb begin
    status_o.is_ff       = (rd_data_q == cfd_pkg::HDR_FIRST);
    status_o.is_fe       = (rd_data_q == cfd_pkg::HDR_SECOND);
    status_o.last_ff     = (last_q == cfd_pkg::HDR_FIRST);
    status_o.short_store = (fill_q < CW'(cfd_pkg::MIN_FRAME));
    status_o.len_bad     = (len_q < 32'(cfd_pkg::MIN_LENGTH)) ||
                           (len_q > 32'(STORE_DEPTH - cfd_pkg::FRAME_EXTRA));
    status_o.incomplete  = (fill_q < total_o);
    status_o.sum_ok      = (sum_q == want_q);
    status_o.empty_frame = (total_o == CW'(cfd_pkg::MIN_FRAME));
    status_o.out_free    = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign command_code_o = out_cmd_q;
  assign payload_byte_o = out_byte_q;
  assign byte_valid_o   = out_bv_q;
  assign frame_last_o   = out_last_q;

endmodule

`default_nettype wire

FILE: sv/cfd_ctrl.sv
`default_nettype none

module cfd_ctrl #(
  parameter int STORE_DEPTH = cfd_pkg::DEF_STORE_DEPTH,
  localparam int CW = $clog2(STORE_DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire cfd_pkg::status_t status_i,
  input  wire logic [CW-1:0]    fill_i,
  input  wire logic [CW-1:0]    total_i,
  output cfd_pkg::cmd_t         cmd_o,
  output logic [CW-1:0]         rd_off_o,
  output logic [CW-1:0]         drop_amt_o
);

  cfd_pkg::state_e st_q, st_d;
  logic [CW-1:0]   off_q, off_d;
  logic [CW-1:0]   tag_q, tag_d;
  logic            dv_q, dv_d;
  logic            prev_ff_q, prev_ff_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= cfd_pkg::ST_IDLE;
      off_q     <= '0;
      tag_q     <= '0;
      dv_q      <= 1'b0;
      prev_ff_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      off_q     <= off_d;
      tag_q     <= tag_d;
      dv_q      <= dv_d;
      prev_ff_q <= prev_ff_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    off_d      = off_q;
    tag_d      = tag_q;
    dv_d       = 1'b0;
    prev_ff_d  = prev_ff_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    rd_off_o   = off_q;
    drop_amt_o = '0;

    case (st_q)
      cfd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        off_d      = '0;
        if (in_valid_i) begin
          cmd_o.op = cfd_pkg::OP_PUSH;
          st_d     = cfd_pkg::ST_SCAN;
        end
      end

      cfd_pkg::ST_SCAN: begin
        // Stream the store from the front, one byte per cycle, and look
        // for a header pair in the data returned for the previous offset.
        off_d = off_q + CW'(1);
        tag_d = off_q;
        dv_d  = 1'b1;
        if (dv_q) begin
          prev_ff_d = status_i.is_ff;
          if ((tag_q != '0) && prev_ff_q && status_i.is_fe) begin
            cmd_o.op   = cfd_pkg::OP_DROP;
            drop_amt_o = tag_q - CW'(1);
            st_d       = cfd_pkg::ST_CHK;
          end else if ((CW+1)'(tag_q) + (CW+1)'(1) >= (CW+1)'(fill_i)) begin
            // No header anywhere: keep only a trailing first header byte.
            if (status_i.last_ff && (fill_i != '0)) begin
              cmd_o.op   = cfd_pkg::OP_DROP;
              drop_amt_o = fill_i - CW'(1);
            end else begin
              cmd_o.op = cfd_pkg::OP_CLEAR;
            end
            st_d = cfd_pkg::ST_IDLE;
          end
        end
      end

      cfd_pkg::ST_CHK: begin
        if (status_i.short_store) begin
          st_d = cfd_pkg::ST_IDLE;
        end else begin
          rd_off_o = CW'(cfd_pkg::LEN_OFF);
          off_d    = CW'(cfd_pkg::LEN_OFF + 1);
          tag_d    = CW'(cfd_pkg::LEN_OFF);
          dv_d     = 1'b1;
          st_d     = cfd_pkg::ST_LEN;
        end
      end

      cfd_pkg::ST_LEN: begin
        off_d     = off_q + CW'(1);
        tag_d     = off_q;
        dv_d      = 1'b1;
        cmd_o.cap = cfd_pkg::CAP_LEN;
        if (tag_q == CW'(cfd_pkg::LEN_LAST)) begin
          st_d = cfd_pkg::ST_LCHK;
        end
      end

      cfd_pkg::ST_LCHK: begin
        if (status_i.len_bad) begin
          cmd_o.op   = cfd_pkg::OP_DROP;
          drop_amt_o = CW'(cfd_pkg::HDR_BYTES);
          off_d      = '0;
          st_d       = cfd_pkg::ST_SCAN;
        end else if (status_i.incomplete) begin
          st_d = cfd_pkg::ST_IDLE;
        end else begin
          rd_off_o      = CW'(cfd_pkg::CMD_OFF);
          off_d         = CW'(cfd_pkg::CMD_OFF + 1);
          tag_d         = CW'(cfd_pkg::CMD_OFF);
          dv_d          = 1'b1;
          cmd_o.clr_acc = 1'b1;
          st_d          = cfd_pkg::ST_SUM;
        end
      end

      cfd_pkg::ST_SUM: begin
        // Command word, payload bytes into the sum, then the checksum word.
        off_d = off_q + CW'(1);
        tag_d = off_q;
        dv_d  = 1'b1;
        if (tag_q < CW'(cfd_pkg::PAYLOAD_OFF)) begin
          cmd_o.cap = cfd_pkg::CAP_CMD;
        end else if (tag_q < total_i - CW'(2)) begin
          cmd_o.cap = cfd_pkg::CAP_SUM;
        end else begin
          cmd_o.cap = cfd_pkg::CAP_WANT;
        end
        if (tag_q == total_i - CW'(1)) begin
          st_d = cfd_pkg::ST_SCHK;
        end
      end

      cfd_pkg::ST_SCHK: begin
        if (!status_i.sum_ok) begin
          cmd_o.op   = cfd_pkg::OP_DROP;
          drop_amt_o = CW'(cfd_pkg::HDR_BYTES);
          off_d      = '0;
          st_d       = cfd_pkg::ST_SCAN;
        end else begin
          off_d = CW'(cfd_pkg::PAYLOAD_OFF);
          st_d  = cfd_pkg::ST_EM_RD;
        end
      end

      cfd_pkg::ST_EM_RD: begin
        st_d = cfd_pkg::ST_EM_WR;
      end

      cfd_pkg::ST_EM_WR: begin
        if (status_i.out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.out_empty = status_i.empty_frame;
          cmd_o.out_last  = status_i.empty_frame || (off_q == total_i - CW'(3));
          if (cmd_o.out_last) begin
            cmd_o.op   = cfd_pkg::OP_DROP;
            drop_amt_o = total_i;
            off_d      = '0;
            st_d       = cfd_pkg::ST_SCAN;
          end else begin
            off_d = off_q + CW'(1);
            st_d  = cfd_pkg::ST_EM_RD;
          end
        end
      end

      default: begin
        st_d = cfd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/checksummed_frame_deframer_core.sv
// A byte that completes no frame is handled by a header scan alone while fewer than 10 bytes
// are held from the header on, and by a header scan and a length read once the length field
// is present. A byte that completes a frame adds a checksum pass over the frame and a read
// and a write per result word; each failed header or checksum adds a rescan of the store.
// Throughput: one byte at a time, set by the single read port of the byte store.
// Reset (rst_ni low, asynchronous) empties the store and the output register.
`default_nettype none

module checksummed_frame_deframer_core #(
  parameter int STORE_DEPTH = cfd_pkg::DEF_STORE_DEPTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cfd_in_if.sink      rx_i,
  cfd_out_if.source   res_o
);

  localparam int CW = $clog2(STORE_DEPTH + 1);

  // Command and status between the sequencer and the store datapath.
  cfd_pkg::cmd_t    cmd;
  cfd_pkg::status_t status;
  logic [CW-1:0]    rd_off;
  logic [CW-1:0]    drop_amt;
  logic [CW-1:0]    fill;
  logic [CW-1:0]    total;

  // The sequencer walks the ring store: it hunts for the header, gathers the
  // length field, sums the payload against the trailing checksum and finally
  // replays the payload into the output register, one word per result.
  cfd_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .status_i   (status),
    .fill_i     (fill),
    .total_i    (total),
    .cmd_o      (cmd),
    .rd_off_o   (rd_off),
    .drop_amt_o (drop_amt)
  );

  // The datapath holds the byte store as a ring with a head pointer and a
  // fill count, so dropping bytes from the front is a pointer move. Its
  // output register lets a finished word wait while the next byte comes in.
  cfd_dp #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_off_i       (rd_off),
    .drop_amt_i     (drop_amt),
    .in_byte_i      (rx_i.rx_byte),
    .out_ready_i    (res_o.ready),
    .status_o       (status),
    .fill_o         (fill),
    .total_o        (total),
    .out_valid_o    (res_o.valid),
    .command_code_o (res_o.command_code),
    .payload_byte_o (res_o.payload_byte),
    .byte_valid_o   (res_o.byte_valid),
    .frame_last_o   (res_o.frame_last)
  );

endmodule

`default_nettype wire
